// File: rtl/core/mmr_pkg.sv
// Package: shared constants and state type for the modexp / Miller-Rabin block.
package mmr_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int FIELD_W   = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STRIP,
    S_RED,
    S_RED_W,
    S_POW,
    S_MULP,
    S_MULP_W,
    S_MULB,
    S_MULB_W,
    S_MRCHK,
    S_MRSQ,
    S_MRSQ_W,
    S_FIN
  } state_e;

endpackage

// File: rtl/core/mmr_if.sv
// Interfaces: request and result channels of the modexp / Miller-Rabin block.
interface mmr_req_if
  import mmr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               func;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, func, base, exponent, modulus, input ready);
  modport sink   (input valid, func, base, exponent, modulus, output ready);
endinterface

interface mmr_rsp_if
  import mmr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] value;
  logic               probable_prime;
  logic               bad_operand;

  modport source (output valid, value, probable_prime, bad_operand, input ready);
  modport sink   (input valid, value, probable_prime, bad_operand, output ready);
endinterface

// File: rtl/core/modexp_miller_rabin_top.sv
// Top level: modular exponentiation and one-base Miller-Rabin test.
//
// req_i carries one request: func, base, exponent, modulus. rsp_o returns one
// result per request: value, probable_prime, bad_operand. Both channels use
// valid/ready; a request is taken when both are high.
// Operands are taken to WIDTH bits. Each modular product runs on a
// bit-serial multiplier.
// Mode 0: one base reduction, then per exponent bit up to two products.
// Mode 1: the trailing zeros of modulus-1 are stripped one at a time,
// then the power of the odd part is taken, then up to k squarings follow,
// k being the number of trailing zeros. A rejected modulus goes straight
// to the result; a zero exponent still takes the base reduction.
// One request is processed at a time; req_i.ready is high while idle,
// also while a finished result still waits in the output register.
// If rsp_o is stalled, the next result waits in the core until the output
// register frees. Reset clears all control state; no result is pending.
module modexp_miller_rabin_top
  import mmr_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  mmr_req_if.sink  req_i,
  mmr_rsp_if.source rsp_o
);

  localparam int KW = $clog2(WIDTH + 1);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  state_e state_q, state_d;

  logic             func_q, zexp_q, bad_q, prime_q;
  logic [WIDTH-1:0] b_q, e_q, n_q, m_q, p_q;
  logic [KW-1:0]    k_q;

  logic             ov_q, oprime_q, obad_q;
  logic [FIELD_W-1:0] oval_q;

  logic [63:0]      base_x, exp_x, mod_x, p_x;
  logic [WIDTH-1:0] base_w, exp_w, mod_w, one_red, mul_x, mul_y, mul_r;
  logic             mul_start, mul_done, req_acc, in_bad, fin_go;

  assign base_x = 64'(req_i.base);
  assign exp_x  = 64'(req_i.exponent);
  assign mod_x  = 64'(req_i.modulus);
  assign base_w = base_x[WIDTH-1:0];
  assign exp_w  = exp_x[WIDTH-1:0];
  assign mod_w  = mod_x[WIDTH-1:0];
  assign in_bad = req_i.func ? (mod_w < WIDTH'(2)) : (mod_w == '0);
  assign one_red = (n_q == ONE) ? '0 : ONE;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc = req_i.valid && req_i.ready;
  assign fin_go  = !ov_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_acc) begin
        if (in_bad) state_d = S_FIN;
        else if (req_i.func) state_d = S_STRIP;
        else state_d = S_RED;
      end
      S_STRIP:  if (e_q[0]) state_d = S_RED;
      S_RED:    state_d = S_RED_W;
      S_RED_W:  if (mul_done) state_d = S_POW;
      S_POW: begin
        if (e_q == '0) begin
          if (!func_q || p_q == ONE) state_d = S_FIN;
          else state_d = S_MRCHK;
        end else if (e_q[0]) state_d = S_MULP;
        else state_d = S_MULB;
      end
      S_MULP:   state_d = S_MULP_W;
      S_MULP_W: if (mul_done) state_d = S_MULB;
      S_MULB:   state_d = S_MULB_W;
      S_MULB_W: if (mul_done) state_d = S_POW;
      S_MRCHK: begin
        if (k_q == '0 || p_q == m_q || p_q == ONE) state_d = S_FIN;
        else state_d = S_MRSQ;
      end
      S_MRSQ:   state_d = S_MRSQ_W;
      S_MRSQ_W: if (mul_done) state_d = S_MRCHK;
      S_FIN:    if (fin_go) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_x     = p_q;
    mul_y     = b_q;
    case (state_q)
      S_RED: begin
        mul_start = 1'b1;
        mul_x     = one_red;
        mul_y     = b_q;
      end
      S_MULP: begin
        mul_start = 1'b1;
        mul_x     = p_q;
        mul_y     = b_q;
      end
      S_MULB: begin
        mul_start = 1'b1;
        mul_x     = b_q;
        mul_y     = b_q;
      end
      S_MRSQ: begin
        mul_start = 1'b1;
        mul_x     = p_q;
        mul_y     = p_q;
      end
      default: ;
    endcase
  end

  mmr_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .n_i     (n_q),
    .done_o  (mul_done),
    .r_o     (mul_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (req_acc) begin
        func_q  <= req_i.func;
        zexp_q  <= !req_i.func && (exp_w == '0);
        bad_q   <= in_bad;
        prime_q <= 1'b0;
        b_q     <= base_w;
        n_q     <= mod_w;
        m_q     <= mod_w - ONE;
        e_q     <= req_i.func ? (mod_w - ONE) : exp_w;
        k_q     <= '0;
      end
      S_STRIP: if (!e_q[0]) begin
        e_q <= e_q >> 1;
        k_q <= k_q + 1'b1;
      end
      S_RED_W: if (mul_done) begin
        b_q <= mul_r;
        p_q <= one_red;
      end
      S_POW: if (e_q == '0 && func_q && p_q == ONE) prime_q <= 1'b1;
      S_MULP_W: if (mul_done) p_q <= mul_r;
      S_MULB_W: if (mul_done) begin
        b_q <= mul_r;
        e_q <= e_q >> 1;
      end
      S_MRCHK: if (k_q != '0 && p_q == m_q) prime_q <= 1'b1;
      S_MRSQ_W: if (mul_done) begin
        p_q <= mul_r;
        k_q <= k_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign p_x = 64'(p_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == S_FIN && fin_go) begin
      ov_q <= 1'b1;
    end else if (rsp_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && fin_go) begin
      obad_q   <= bad_q;
      oprime_q <= !bad_q && func_q && prime_q;
      if (bad_q || func_q) oval_q <= '0;
      else if (zexp_q) oval_q <= FIELD_W'(1);
      else oval_q <= p_x[FIELD_W-1:0];
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.value          = oval_q;
  assign rsp_o.probable_prime = oprime_q;
  assign rsp_o.bad_operand    = obad_q;

`ifndef ASSERT_OFF
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(oprime_q && obad_q)) else $error("prime and error flags both set");
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> state_q != S_IDLE) else $error("request accepted but core idle");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_RED_W || state_q == S_MULP_W ||
                  state_q == S_MULB_W || state_q == S_MRSQ_W))
    else $error("product finished outside a wait state");
`endif

endmodule

// File: rtl/core/mmr_mulmod.sv
// Bit-serial modular multiplier: x * y mod n, one bit of y per cycle, x < n.
module mmr_mulmod
  import mmr_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] n_i,
  output logic             done_o,
  output logic [WIDTH-1:0] r_o
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] gap;
    gap = n - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  logic [WIDTH-1:0] r_q, x_q, y_q, n_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [WIDTH-1:0] dbl, r_d;

  always_comb begin
    dbl = add_mod(r_q, r_q, n_q);
    r_d = y_q[WIDTH-1] ? add_mod(dbl, x_q, n_q) : dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_LAST;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      x_q <= x_i;
      y_q <= y_i;
      n_q <= n_i;
    end else if (busy_q) begin
      r_q <= r_d;
      y_q <= {y_q[WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("multiply started while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held over two cycles");
  a_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (r_q < n_q)) else $error("product not reduced");
`endif

endmodule
